FILE: design/psa_pkg.sv
// Shared types and constants for the shoelace polygon area block.
`default_nettype none
package psa_pkg;

	localparam int COORD_W     = 16;
	localparam int PROD_W      = 2 * COORD_W;
	localparam int TERM_W      = PROD_W + 2;
	// Exact for up to 512 vertices of 33-bit signed terms; wraps beyond that.
	localparam int SUM_W       = 42;
	localparam int AREA_W      = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	// One vertex worth of work for the accumulator side.
	typedef struct packed {
		logic [COORD_W-1:0] prev_x;
		logic [COORD_W-1:0] prev_y;
		logic [COORD_W-1:0] cur_x;
		logic [COORD_W-1:0] cur_y;
		logic [COORD_W-1:0] first_x;
		logic [COORD_W-1:0] first_y;
		logic               start;
		logic               last;
	} psa_job_t;

	// Queue status: full for the front end, empty for the back end.
	typedef struct packed {
		logic full;
		logic empty;
	} psa_qstat_t;

endpackage
`default_nettype wire

FILE: design/psa_if.sv
// Channel interfaces: vertex input and area result.
`default_nettype none
interface psa_vertex_if;
	import psa_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] vertex_x;
	logic [COORD_W-1:0] vertex_y;
	logic               last_vertex;

	modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
		input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
		output ready);
endinterface

interface psa_area_if;
	import psa_pkg::*;
	logic              valid;
	logic              ready;
	logic [AREA_W-1:0] area;
	logic              saturated;

	modport source (output valid, output area, output saturated, input ready);
	modport sink (input valid, input area, input saturated, output ready);
endinterface
`default_nettype wire

FILE: design/psa_front.sv
// Front end: tracks polygon boundaries and turns each vertex into an edge job.
`default_nettype none
module psa_front
	import psa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	psa_vertex_if.sink vertex,
	input  wire psa_qstat_t qstat,
	output logic       push,
	output psa_job_t   job
);

	logic [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic               in_poly_q;

	assign vertex.ready = !qstat.full;
	assign push         = vertex.valid && !qstat.full;

	// A starting vertex stands in for prev and first so its terms come out zero.
	always_comb begin
		job.cur_x   = vertex.vertex_x;
		job.cur_y   = vertex.vertex_y;
		job.prev_x  = in_poly_q ? prev_x_q  : vertex.vertex_x;
		job.prev_y  = in_poly_q ? prev_y_q  : vertex.vertex_y;
		job.first_x = in_poly_q ? first_x_q : vertex.vertex_x;
		job.first_y = in_poly_q ? first_y_q : vertex.vertex_y;
		job.start   = !in_poly_q;
		job.last    = vertex.last_vertex;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			in_poly_q <= 1'b0;
		end else if (push) begin
			prev_x_q  <= vertex.vertex_x;
			prev_y_q  <= vertex.vertex_y;
			if (!in_poly_q) begin
				first_x_q <= vertex.vertex_x;
				first_y_q <= vertex.vertex_y;
			end
			in_poly_q <= !vertex.last_vertex;
		end
	end

endmodule
`default_nettype wire

FILE: design/psa_queue.sv
// Short job queue between the front end and the accumulator.
`default_nettype none
module psa_queue
	import psa_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire psa_job_t push_job,
	input  wire logic     pop,
	output psa_job_t      head,
	output psa_qstat_t    qstat
);

	psa_job_t           mem_q [QUEUE_DEPTH];
	logic [QIDX_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/psa_back.sv
// Back end: cross products, running sum and area/saturation output register.
`default_nettype none
module psa_back
	import psa_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire psa_job_t   head,
	input  wire psa_qstat_t qstat,
	output logic            pop,
	psa_area_if.source      result
);

	logic                     en;
	logic                     v_s1, v_s2, v_s3;
	logic                     start_s1, start_s2;
	logic                     last_s1, last_s2, last_s3;
	logic [PROD_W-1:0]        pa_s1, pb_s1, pc_s1, pd_s1;
	logic signed [TERM_W-1:0] term_s2;
	logic signed [TERM_W-1:0] edge_term, close_term;
	logic [SUM_W-1:0]         acc_q;
	logic [SUM_W-1:0]         acc_base;
	logic [SUM_W-1:0]         mag;
	logic [SUM_W-2:0]         half;
	logic                     out_valid_q;
	logic [AREA_W-1:0]        area_q;
	logic                     sat_q;

	// Whole back end holds while a finished area waits to be taken.
	assign en  = !out_valid_q || result.ready;
	assign pop = en && !qstat.empty;

	assign edge_term  = $signed({2'b00, pa_s1}) - $signed({2'b00, pb_s1});
	assign close_term = last_s1 ? ($signed({2'b00, pc_s1}) - $signed({2'b00, pd_s1}))
		: '0;
	assign acc_base   = start_s2 ? '0 : acc_q;

	// Most negative sum negates to itself, which read unsigned is 2^41.
	assign mag  = acc_q[SUM_W-1] ? (~acc_q + 1'b1) : acc_q;
	assign half = mag[SUM_W-1:1];

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1   <= head.prev_x * head.cur_y;
			pb_s1   <= head.prev_y * head.cur_x;
			pc_s1   <= head.cur_x * head.first_y;
			pd_s1   <= head.cur_y * head.first_x;
			term_s2 <= edge_term + close_term;
			if (v_s3 && last_s3) begin
				sat_q  <= |half[SUM_W-2:AREA_W];
				area_q <= (|half[SUM_W-2:AREA_W]) ? AREA_MAX : half[AREA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			start_s1    <= 1'b0;
			start_s2    <= 1'b0;
			last_s1     <= 1'b0;
			last_s2     <= 1'b0;
			last_s3     <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= !qstat.empty;
			start_s1    <= head.start;
			last_s1     <= head.last;
			v_s2        <= v_s1;
			start_s2    <= start_s1;
			last_s2     <= last_s1;
			v_s3        <= v_s2;
			last_s3     <= last_s2;
			if (v_s2) begin
				acc_q <= acc_base + {{(SUM_W - TERM_W){term_s2[TERM_W-1]}}, term_s2};
			end
			out_valid_q <= v_s3 && last_s3;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.area      = area_q;
	assign result.saturated = sat_q;

endmodule
`default_nettype wire

FILE: design/polygon_area_shoelace.sv
// Top level: shoelace polygon area, one vertex transfer per cycle while the job queue has room.
// Path: a closing vertex's job passes the queue, product, term and sum registers to the area register.
// Throughput: one vertex per cycle through the multiply stage and accumulator, unless a waiting area stalls them.
// A 4-entry job queue decouples vertex intake from the accumulator side.
// Reset (arst_n low) clears polygon tracking, the queue, pipeline valids and the sum.
`default_nettype none
module polygon_area_shoelace
	import psa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	psa_vertex_if.sink vertex,
	psa_area_if.source result
);

	logic       push, pop;
	psa_job_t   job, head;
	psa_qstat_t qstat;

	psa_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.vertex (vertex),
		.qstat  (qstat),
		.push   (push),
		.job    (job)
	);

	psa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	psa_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire

FILE: design/psa_checker.sv
// Port-level checks for the polygon area block, bound to the top level.
`default_nettype none
module psa_checker
	import psa_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire logic [AREA_W-1:0] res_area,
	input wire logic              res_saturated
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	a_sat_clamps: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_saturated |-> res_area == AREA_MAX)
		else $error("saturated area not clamped");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_area) && $stable(res_saturated))
		else $error("result changed while stalled");

endmodule

bind polygon_area_shoelace psa_checker u_psa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_area      (result.area),
	.res_saturated (result.saturated)
);
`default_nettype wire

FILE: dv/polygon_area_shoelace_tb.sv
// Testbench for polygon_area_shoelace: directed and random polygons checked against a predictor.
`timescale 1ns / 1ps
module polygon_area_shoelace_tb;
	import psa_pkg::*;

	localparam int ITEM_TARGET = 1800;
	localparam int CYCLE_LIMIT = 400000;
	localparam int WRAP_VERTS  = 1100;
	localparam int SETTLE_CYC  = 12;
	localparam int N_DIRECTED  = 25;

	typedef struct packed {
		logic [AREA_W-1:0] area;
		logic              sat;
	} area_res_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
		logic               typed;
		logic [AREA_W-1:0]  area;
		logic               sat;
	} vertex_row_t;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_EVERY_FOURTH,
		RX_LONG_STALL
	} rx_mode_t;

	logic clk;
	logic arst_n;

	psa_vertex_if vertex_ch();
	psa_area_if   result_ch();

	polygon_area_shoelace DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.vertex (vertex_ch),
		.result (result_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Predictor state
	logic [COORD_W-1:0] poly_first_x, poly_first_y;
	logic [COORD_W-1:0] poly_prev_x, poly_prev_y;
	logic [SUM_W-1:0]   cross_acc;
	logic               poly_open;

	area_res_t area_expected[$];
	area_res_t area_want;
	int        mismatch_count;
	int        vertex_count;
	int        burst_left;
	int        cycle_count;

	// ax*by - ay*bx, modulo 2^SUM_W
	function automatic logic [SUM_W-1:0] cross_term(input logic [COORD_W-1:0] ax, ay, bx, by);
		cross_term = (SUM_W'(ax) * SUM_W'(by)) - (SUM_W'(ay) * SUM_W'(bx));
	endfunction

	task automatic shoelace_step(input logic [COORD_W-1:0] x, y, input logic last,
		output bit has_area, output area_res_t res);
		logic [SUM_W:0] mag;
		logic [SUM_W:0] half;
		if (!poly_open) begin
			poly_first_x = x;
			poly_first_y = y;
			cross_acc    = '0;
		end else begin
			cross_acc = cross_acc + cross_term(poly_prev_x, poly_prev_y, x, y);
		end
		poly_prev_x = x;
		poly_prev_y = y;
		has_area = 1'b0;
		res = '0;
		if (!last) begin
			poly_open = 1'b1;
		end else begin
			// closing edge back to the first vertex
			cross_acc = cross_acc + cross_term(x, y, poly_first_x, poly_first_y);
			poly_open = 1'b0;
			has_area = 1'b1;
			if (cross_acc[SUM_W-1])
				mag = ((SUM_W+1)'(1) << SUM_W) - {1'b0, cross_acc};
			else
				mag = {1'b0, cross_acc};
			half = mag >> 1;
			if (half > (SUM_W+1)'(AREA_MAX)) begin
				res.area = AREA_MAX;
				res.sat  = 1'b1;
			end else begin
				res.area = half[AREA_W-1:0];
				res.sat  = 1'b0;
			end
		end
	endtask

	function automatic logic [COORD_W-1:0] pick_coord(input int spread);
		case (spread)
			0: pick_coord = COORD_W'($urandom_range(0, 65535));
			1: pick_coord = COORD_W'($urandom_range(0, 255));
			2: pick_coord = COORD_W'($urandom_range(65280, 65535));
			default: begin
				case ($urandom_range(0, 3))
					0: pick_coord = '0;
					1: pick_coord = '1;
					default: pick_coord = COORD_W'($urandom_range(0, 65535));
				endcase
			end
		endcase
	endfunction

	// Drive one vertex from a negedge and hold it until the transfer.
	task automatic send_vertex(input logic [COORD_W-1:0] x, y, input logic last,
		input bit typed = 1'b0, input area_res_t typed_res = '0);
		int        gap_len;
		bit        has_area;
		area_res_t res;
		@(negedge clk);
		if (burst_left == 0) begin
			gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap_len != 0) begin
				vertex_ch.valid = 1'b0;
				repeat (gap_len) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		vertex_ch.valid       = 1'b1;
		vertex_ch.vertex_x    = x;
		vertex_ch.vertex_y    = y;
		vertex_ch.last_vertex = last;
		@(posedge clk);
		while (!vertex_ch.ready) @(posedge clk);
		burst_left--;
		vertex_count++;
		shoelace_step(x, y, last, has_area, res);
		if (has_area)
			area_expected.push_back(typed ? typed_res : res);
	endtask

	task automatic drain_results();
		@(negedge clk);
		vertex_ch.valid = 1'b0;
		burst_left = 0;
		while (area_expected.size() != 0) @(posedge clk);
	endtask

	// Result side: checks every transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (area_expected.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected area transfer: area=%0d saturated=%0b",
						$realtime, result_ch.area, result_ch.saturated);
			end else begin
				area_want = area_expected.pop_front();
				if (result_ch.area !== area_want.area ||
						result_ch.saturated !== area_want.sat) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: area mismatch: exp area=%0d sat=%0b, got area=%0d sat=%0b",
							$realtime, area_want.area, area_want.sat,
							result_ch.area, result_ch.saturated);
				end
			end
		end
	end

	// Receiver stall pattern, with a new random mode drawn whenever a phase runs out
	initial begin : rx_stalls
		rx_mode_t rx_mode;
		int       phase_left;
		int       stall_left;
		int       rx_tick;
		rx_mode    = RX_ALWAYS;
		phase_left = 0;
		stall_left = 0;
		rx_tick    = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (phase_left == 0) begin
				rx_mode    = rx_mode_t'($urandom_range(0, 3));
				phase_left = $urandom_range(50, 300);
			end
			phase_left--;
			rx_tick++;
			case (rx_mode)
				RX_ALWAYS:       result_ch.ready = 1'b1;
				RX_COIN:         result_ch.ready = 1'($urandom_range(0, 1));
				RX_EVERY_FOURTH: result_ch.ready = (rx_tick % 4 == 0);
				RX_LONG_STALL: begin
					if (stall_left != 0) begin
						result_ch.ready = 1'b0;
						stall_left--;
					end else begin
						result_ch.ready = 1'b1;
						if ($urandom_range(0, 7) == 0)
							stall_left = $urandom_range(4, 20);
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		vertex_row_t             directed_rows [N_DIRECTED];
		int                      n_verts;
		int                      spread;
		int                      pick;
		logic [COORD_W-1:0]      hi_x, hi_y, lo_x, lo_y;
		logic [COORD_W-1:0]      cx, cy;
		bit                      reverse;

		directed_rows = '{
			// single-vertex polygons at both corners
			'{16'd65535, 16'd65535, 1'b1, 1'b1, 16'd0,     1'b0},
			'{16'd0,     16'd0,     1'b1, 1'b1, 16'd0,     1'b0},
			// largest triangle, counterclockwise: clamps
			'{16'd0,     16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
			'{16'd65535, 16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
			'{16'd0,     16'd65535, 1'b1, 1'b1, 16'd65535, 1'b1},
			// 2x2 square
			'{16'd0,     16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
			'{16'd2,     16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
			'{16'd2,     16'd2,     1'b0, 1'b0, 16'd0,     1'b0},
			'{16'd0,     16'd2,     1'b1, 1'b1, 16'd4,     1'b0},
			// largest triangle, clockwise: negative sum, clamps
			'{16'd0,     16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
			'{16'd0,     16'd65535, 1'b0, 1'b0, 16'd0,     1'b0},
			'{16'd65535, 16'd0,     1'b1, 1'b1, 16'd65535, 1'b1},
			// half-unit triangle truncates to zero
			'{16'd0,     16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
			'{16'd1,     16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
			'{16'd0,     16'd1,     1'b1, 1'b1, 16'd0,     1'b0},
			// two-vertex polygon
			'{16'd65535, 16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
			'{16'd0,     16'd65535, 1'b1, 1'b0, 16'd0,     1'b0},
			// area just over the clamp
			'{16'd0,     16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
			'{16'd256,   16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
			'{16'd0,     16'd512,   1'b1, 1'b0, 16'd0,     1'b0},
			// area at the largest unclamped value
			'{16'd0,     16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
			'{16'd255,   16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
			'{16'd0,     16'd514,   1'b1, 1'b0, 16'd0,     1'b0},
			// alternating bit patterns
			'{16'hAAAA,  16'h5555,  1'b0, 1'b0, 16'd0,     1'b0},
			'{16'h5555,  16'hAAAA,  1'b1, 1'b0, 16'd0,     1'b0}
		};

		arst_n                = 1'b0;
		vertex_ch.valid       = 1'b0;
		vertex_ch.vertex_x    = '0;
		vertex_ch.vertex_y    = '0;
		vertex_ch.last_vertex = 1'b0;
		poly_first_x   = '0;
		poly_first_y   = '0;
		poly_prev_x    = '0;
		poly_prev_y    = '0;
		cross_acc      = '0;
		poly_open      = 1'b0;
		mismatch_count = 0;
		vertex_count   = 0;
		burst_left     = 0;
		cycle_count    = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
				directed_rows[i].typed, '{directed_rows[i].area, directed_rows[i].sat});

		// sender holds off until every area has come back
		drain_results();

		// random polygons fill the budget left after the wrap polygon
		while (vertex_count < ITEM_TARGET - WRAP_VERTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				n_verts = 1;
			else if (pick < 70)
				n_verts = $urandom_range(2, 8);
			else if (pick < 90)
				n_verts = $urandom_range(9, 40);
			else if (pick < 97)
				n_verts = $urandom_range(41, 256);
			else
				n_verts = $urandom_range(257, 320);
			spread = $urandom_range(0, 3);
			for (int v = 0; v < n_verts; v++)
				send_vertex(pick_coord(spread), pick_coord(spread), v == n_verts - 1);
			if ($urandom_range(0, 49) == 0)
				drain_results();
		end

		// Long polygon circling the outer corners so the running sum wraps
		reverse = $urandom_range(0, 1);
		for (int v = 0; v < WRAP_VERTS; v++) begin
			hi_x = 16'hFFFF - COORD_W'($urandom_range(0, 3));
			hi_y = 16'hFFFF - COORD_W'($urandom_range(0, 3));
			lo_x = COORD_W'($urandom_range(0, 3));
			lo_y = COORD_W'($urandom_range(0, 3));
			case (v % 4)
				0: begin cx = hi_x; cy = lo_y; end
				1: begin cx = hi_x; cy = hi_y; end
				2: begin cx = lo_x; cy = hi_y; end
				default: begin cx = lo_x; cy = lo_y; end
			endcase
			if (reverse)
				send_vertex(cy, cx, v == WRAP_VERTS - 1);
			else
				send_vertex(cx, cy, v == WRAP_VERTS - 1);
		end

		drain_results();
		repeat (SETTLE_CYC) @(posedge clk);

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
